// ----- hw/rtl/slr_pkg.sv -----
`timescale 1ns / 1ps

package slr_pkg;

  // Item mode codes.
  localparam logic [2:0] MODE_ATTR  = 3'd0;
  localparam logic [2:0] MODE_PAT   = 3'd1;
  localparam logic [2:0] MODE_PAL   = 3'd2;
  localparam logic [2:0] MODE_LINE  = 3'd3;
  localparam logic [2:0] MODE_PIXEL = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_TALL = 2'd0;
  localparam logic [1:0] REG_HALF = 2'd1;
  localparam logic [1:0] REG_SHOW = 2'd2;
  localparam logic [1:0] REG_LEFT = 2'd3;

  localparam int OAM_SPRITES_DEF      = 64;
  localparam int SPRITES_PER_LINE_DEF = 8;
  localparam int LINE_WIDTH           = 256;

  typedef struct packed {
    logic tall;
    logic half;
    logic show;
    logic left;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [12:0] address;
    logic [7:0]  write_data;
    logic [8:0]  scanline;
    logic [7:0]  pixel_x;
    logic [7:0]  bg_pixel;
    logic        hit_armed;
  } item_t;

  // Line buffer write port.
  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } lb_wr_t;

endpackage

// ----- hw/rtl/slr_linebuf.sv -----
`timescale 1ns / 1ps

module slr_linebuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clr,
  input  slr_pkg::lb_wr_t      wr,
  input  logic [7:0]           rd_addr,
  output logic [7:0]           rd_data
);

  logic [7:0]                      mem [slr_pkg::LINE_WIDTH];
  logic [slr_pkg::LINE_WIDTH-1:0]  vld_r;
  logic [7:0]                      rd_q_r;
  logic                            rd_v_r;

  // Storage and registered read.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_q_r <= mem[rd_addr];
  end

  // Per-entry valid bits; an entry not written since the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r  <= '0;
      rd_v_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      rd_v_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_v_r ? rd_q_r : 8'd0;

endmodule

// ----- hw/rtl/slr_core.sv -----
`timescale 1ns / 1ps

module slr_core #(
  parameter int OAM_SPRITES      = slr_pkg::OAM_SPRITES_DEF,
  parameter int SPRITES_PER_LINE = slr_pkg::SPRITES_PER_LINE_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  slr_pkg::cfg_t   cfg,
  input  logic            start,
  input  slr_pkg::item_t  item,
  output logic            busy,
  output logic            done,
  output logic [7:0]      res_pix,
  output logic            res_hit,
  output logic            ovf_status
);

  localparam int CNT_W = $clog2(SPRITES_PER_LINE + 1);
  localparam int IDX_W = (SPRITES_PER_LINE > 1) ? $clog2(SPRITES_PER_LINE) : 1;
  localparam int OI_W  = $clog2(OAM_SPRITES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DSEL  = 4'd1;
  localparam logic [3:0] S_DRD   = 4'd2;
  localparam logic [3:0] S_DPAT0 = 4'd3;
  localparam logic [3:0] S_DPAT1 = 4'd4;
  localparam logic [3:0] S_DPAT2 = 4'd5;
  localparam logic [3:0] S_DPIX  = 4'd6;
  localparam logic [3:0] S_EVRD  = 4'd7;
  localparam logic [3:0] S_EVCMP = 4'd8;
  localparam logic [3:0] S_PIX   = 4'd9;

  logic [3:0]       state_r;
  logic [2:0]       sub_r;
  logic [2:0]       p_r;
  logic [CNT_W-1:0] k_r;
  logic [CNT_W-1:0] km1;
  logic [OI_W-1:0]  ev_i_r;
  logic [8:0]       line_r;
  logic [7:0]       px_r;
  logic [7:0]       bg_r;
  logic             armed_r;
  logic [7:0]       spr_y_r, spr_chr_r, spr_attr_r, spr_x_r;
  logic [5:0]       num_r;
  logic [7:0]       pat_lo_r, pat_hi_r;
  logic [5:0]       next_list_r [SPRITES_PER_LINE];
  logic [5:0]       cur_list_r  [SPRITES_PER_LINE];
  logic [CNT_W-1:0] next_cnt_r, cur_cnt_r;
  logic             ovf_pend_r, ovf_stat_r, active_r;
  logic             done_r;
  logic [7:0]       res_pix_r;
  logic             res_hit_r;

  // Sprite memories.
  logic [7:0]  attr_mem [256];
  logic [7:0]  pat_mem  [8192];
  logic [5:0]  pal_mem  [16];
  logic [7:0]  attr_ra;
  logic [7:0]  attr_q_r;
  logic [12:0] pat_ra;
  logic [7:0]  pat_q_r;

  // Pattern address of the current sprite row.
  logic [3:0]  hmask;
  logic [3:0]  row_raw, row;
  logic [12:0] pat_lo_addr, pat_hi_addr;

  // Pixel stage signals.
  logic [2:0]  bitsel;
  logic [1:0]  pv;
  logic [8:0]  xsum;
  logic        pix_ok;
  slr_pkg::lb_wr_t lb_wr;
  logic [7:0]  lb_rd_data;
  logic        lb_clr;

  // Evaluation compare.
  logic [8:0]  ev_top;
  logic        ev_in;

  // Pixel merge.
  logic [7:0]  mg_pix;
  logic        mg_hit;

  logic go_line, line_act_nxt;

  assign km1 = k_r - CNT_W'(1);

  assign hmask   = cfg.tall ? 4'd15 : 4'd7;
  assign row_raw = (line_r[3:0] - spr_y_r[3:0] - 4'd1) & hmask;
  assign row     = spr_attr_r[7] ? (hmask - row_raw) : row_raw;
  assign pat_lo_addr = cfg.tall ? {spr_chr_r[0], spr_chr_r[7:1], row[3], 1'b0, row[2:0]}
                                : {cfg.half, spr_chr_r, 1'b0, row[2:0]};
  assign pat_hi_addr = pat_lo_addr + 13'd8;

  // Attribute read address: sprite fields while drawing, Y bytes while evaluating.
  always_comb begin
    if (state_r == S_EVRD) begin
      attr_ra = {6'(ev_i_r), 2'b00};
    end else begin
      attr_ra = {num_r, sub_r[1:0]};
    end
  end

  assign pat_ra = (state_r == S_DPAT0) ? pat_lo_addr : pat_hi_addr;

  always_ff @(posedge clk) begin
    if (start && item.mode == slr_pkg::MODE_ATTR) begin
      attr_mem[item.address[7:0]] <= item.write_data;
    end
    attr_q_r <= attr_mem[attr_ra];
  end

  always_ff @(posedge clk) begin
    if (start && item.mode == slr_pkg::MODE_PAT) begin
      pat_mem[item.address] <= item.write_data;
    end
    pat_q_r <= pat_mem[pat_ra];
  end

  always_ff @(posedge clk) begin
    if (start && item.mode == slr_pkg::MODE_PAL) begin
      pal_mem[item.address[3:0]] <= item.write_data[5:0];
    end
  end

  // One sprite pixel per cycle into the line buffer.
  assign bitsel = spr_attr_r[6] ? p_r : (3'd7 - p_r);
  assign pv     = {pat_hi_r[bitsel], pat_lo_r[bitsel]};
  assign xsum   = {1'b0, spr_x_r} + {6'd0, p_r};
  assign pix_ok = !xsum[8] && !(!cfg.left && xsum < 9'd8);

  always_comb begin
    lb_wr.en   = (state_r == S_DPIX) && pix_ok && (pv != 2'd0);
    lb_wr.addr = xsum[7:0];
    lb_wr.data = {~spr_attr_r[5], num_r == 6'd0, pal_mem[{spr_attr_r[1:0], pv}]};
  end

  assign go_line      = start && item.mode == slr_pkg::MODE_LINE;
  assign line_act_nxt = (item.scanline != 9'd0) && (next_cnt_r != '0) && cfg.show;
  assign lb_clr       = go_line && line_act_nxt;

  slr_linebuf u_linebuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (lb_clr),
    .wr      (lb_wr),
    .rd_addr (item.pixel_x),
    .rd_data (lb_rd_data)
  );

  assign ev_top = {1'b0, attr_q_r} + {5'd0, hmask} + 9'd1;
  assign ev_in  = ({1'b0, attr_q_r} <= line_r) && (ev_top > line_r);

  // Merge of sprite and background for a pixel item.
  always_comb begin
    mg_pix = bg_r;
    mg_hit = 1'b0;
    if (active_r) begin
      mg_hit = armed_r && (px_r != 8'd255) && lb_rd_data[6] && !bg_r[6];
      if (lb_rd_data != 8'd0 && (lb_rd_data[7] || bg_r[6])) begin
        mg_pix = lb_rd_data;
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      done_r     <= 1'b0;
      next_cnt_r <= '0;
      cur_cnt_r  <= '0;
      ovf_pend_r <= 1'b0;
      ovf_stat_r <= 1'b0;
      active_r   <= 1'b0;
      for (int i = 0; i < SPRITES_PER_LINE; i++) begin
        next_list_r[i] <= 6'd0;
        cur_list_r[i]  <= 6'd0;
      end
    end else begin
      done_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            line_r    <= item.scanline;
            px_r      <= item.pixel_x;
            bg_r      <= item.bg_pixel;
            armed_r   <= item.hit_armed;
            res_pix_r <= 8'd0;
            res_hit_r <= 1'b0;
            ev_i_r    <= '0;
            case (item.mode)
              slr_pkg::MODE_LINE: begin
                if (item.scanline == 9'd0) begin
                  next_cnt_r <= '0;
                  cur_cnt_r  <= '0;
                  ovf_pend_r <= 1'b0;
                  active_r   <= 1'b0;
                  for (int i = 0; i < SPRITES_PER_LINE; i++) begin
                    next_list_r[i] <= 6'd0;
                    cur_list_r[i]  <= 6'd0;
                  end
                  state_r <= S_EVRD;
                end else begin
                  cur_cnt_r  <= next_cnt_r;
                  next_cnt_r <= '0;
                  ovf_stat_r <= ovf_pend_r;
                  ovf_pend_r <= 1'b0;
                  active_r   <= line_act_nxt;
                  for (int i = 0; i < SPRITES_PER_LINE; i++) begin
                    cur_list_r[i] <= next_list_r[i];
                  end
                  k_r     <= next_cnt_r;
                  state_r <= line_act_nxt ? S_DSEL : S_EVRD;
                end
              end
              slr_pkg::MODE_PIXEL: begin
                state_r <= S_PIX;
              end
              default: begin
                done_r <= 1'b1;
              end
            endcase
          end
        end
        S_DSEL: begin
          num_r   <= cur_list_r[km1[IDX_W-1:0]];
          sub_r   <= 3'd0;
          state_r <= S_DRD;
        end
        S_DRD: begin
          case (sub_r)
            3'd1:    spr_y_r    <= attr_q_r;
            3'd2:    spr_chr_r  <= attr_q_r;
            3'd3:    spr_attr_r <= attr_q_r;
            3'd4:    spr_x_r    <= attr_q_r;
            default: ;
          endcase
          sub_r <= sub_r + 3'd1;
          if (sub_r == 3'd4) begin
            state_r <= S_DPAT0;
          end
        end
        S_DPAT0: begin
          state_r <= S_DPAT1;
        end
        S_DPAT1: begin
          pat_lo_r <= pat_q_r;
          state_r  <= S_DPAT2;
        end
        S_DPAT2: begin
          pat_hi_r <= pat_q_r;
          p_r      <= 3'd0;
          state_r  <= S_DPIX;
        end
        S_DPIX: begin
          p_r <= p_r + 3'd1;
          if (p_r == 3'd7) begin
            k_r     <= km1;
            state_r <= (km1 == '0) ? S_EVRD : S_DSEL;
          end
        end
        S_EVRD: begin
          state_r <= S_EVCMP;
        end
        S_EVCMP: begin
          if (ev_in && next_cnt_r == CNT_W'(SPRITES_PER_LINE)) begin
            ovf_pend_r <= 1'b1;
            done_r     <= 1'b1;
            state_r    <= S_IDLE;
          end else begin
            if (ev_in) begin
              next_list_r[next_cnt_r[IDX_W-1:0]] <= 6'(ev_i_r);
              next_cnt_r <= next_cnt_r + CNT_W'(1);
            end
            if (ev_i_r == OI_W'(OAM_SPRITES - 1)) begin
              done_r  <= 1'b1;
              state_r <= S_IDLE;
            end else begin
              ev_i_r  <= ev_i_r + OI_W'(1);
              state_r <= S_EVRD;
            end
          end
        end
        S_PIX: begin
          res_pix_r <= mg_pix;
          res_hit_r <= mg_hit;
          done_r    <= 1'b1;
          state_r   <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy       = (state_r != S_IDLE) || done_r;
  assign done       = done_r;
  assign res_pix    = res_pix_r;
  assign res_hit    = res_hit_r;
  assign ovf_status = ovf_stat_r;

endmodule

// ----- hw/rtl/sprite_line_evaluate_render.sv -----
`timescale 1ns / 1ps

// Sprite line unit. Input items arrive on the in_ channel (valid/stall) and
// write sprite attribute memory, pattern memory or the sprite palette, start
// a scanline, or present one background pixel. Every item gives exactly one
// result on the out_ channel: the merged pixel and sprite-zero hit for pixel
// items, zeros otherwise, and the overflow status flag in every result.
// Write and unknown items give their result straight from the idle state;
// pixel items pass through the merge state first. A line start walks the
// sprite list through the attribute and pattern memories when the line is
// drawn (four attribute reads, two pattern reads, up to eight pixel writes
// per listed sprite); evaluation then uses the single attribute read port.
// One item is in flight at a time; the next transfer is taken once its
// result sits in the output register and that register is free to reload.
// Reset (rst_n low, synchronous) clears lists, counts, flags, the line buffer
// valid bits and the configuration registers; the memories stay undefined.
// While out_stall is high a valid result holds and no further item is taken.
// Configuration is written on the APB-style port, one bit per register.
module sprite_line_evaluate_render #(
  parameter int OAM_SPRITES      = slr_pkg::OAM_SPRITES_DEF,
  parameter int SPRITES_PER_LINE = slr_pkg::SPRITES_PER_LINE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [12:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic [8:0]  in_scanline,
  input  logic [7:0]  in_pixel_x,
  input  logic [7:0]  in_bg_pixel,
  input  logic        in_hit_armed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_pixel_out,
  output logic        out_sprite_zero_hit,
  output logic        out_overflow_flag
);

  slr_pkg::cfg_t  cfg_r;
  slr_pkg::item_t item;
  logic           start, busy, done;
  logic [7:0]     res_pix;
  logic           res_hit, ovf_status;
  logic           out_valid_r;
  logic [7:0]     out_pix_r;
  logic           out_hit_r, out_ovf_r;
  logic           reg_bit;

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        slr_pkg::REG_TALL: cfg_r.tall <= pwdata[0];
        slr_pkg::REG_HALF: cfg_r.half <= pwdata[0];
        slr_pkg::REG_SHOW: cfg_r.show <= pwdata[0];
        slr_pkg::REG_LEFT: cfg_r.left <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      slr_pkg::REG_TALL: reg_bit = cfg_r.tall;
      slr_pkg::REG_HALF: reg_bit = cfg_r.half;
      slr_pkg::REG_SHOW: reg_bit = cfg_r.show;
      slr_pkg::REG_LEFT: reg_bit = cfg_r.left;
      default:           reg_bit = 1'b0;
    endcase
  end

  assign prdata = {31'd0, reg_bit};

  // Input transfer.
  assign in_stall = busy || (out_valid_r && out_stall);
  assign start    = in_valid && !in_stall;

  always_comb begin
    item.mode       = in_mode;
    item.address    = in_address;
    item.write_data = in_write_data;
    item.scanline   = in_scanline;
    item.pixel_x    = in_pixel_x;
    item.bg_pixel   = in_bg_pixel;
    item.hit_armed  = in_hit_armed;
  end

  slr_core #(
    .OAM_SPRITES      (OAM_SPRITES),
    .SPRITES_PER_LINE (SPRITES_PER_LINE)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .start      (start),
    .item       (item),
    .busy       (busy),
    .done       (done),
    .res_pix    (res_pix),
    .res_hit    (res_hit),
    .ovf_status (ovf_status)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_pix_r <= res_pix;
      out_hit_r <= res_hit;
      out_ovf_r <= ovf_status;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pixel_out       = out_pix_r;
  assign out_sprite_zero_hit = out_hit_r;
  assign out_overflow_flag   = out_ovf_r;

endmodule
